/* hdl/ges_pkg.sv */
// Shared types, widths and codes for the Gaussian elimination solver.
package ges_pkg;

  localparam int DEF_MAX_ORDER     = 16;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int DATA_W    = 32;
  localparam int ORDER_W   = 5;
  localparam int TOL_W     = 31;
  localparam int OUT_IDX_W = 4;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SINGULAR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

  localparam logic [1:0] WS_INPUT = 2'd0;
  localparam logic [1:0] WS_MEMQ  = 2'd1;
  localparam logic [1:0] WS_T1    = 2'd2;
  localparam logic [1:0] WS_DIFF  = 2'd3;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] element_value;
    logic                     last_element;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]     solution_index;
    logic signed [DATA_W-1:0] solution_value;
    logic [STATUS_W-1:0]      solve_status;
    logic                     last_result;
  } out_item_t;

  typedef struct packed {
    logic                mem_rd;
    logic                mem_wr;
    logic                use_lin;
    logic [1:0]          wr_src;
    logic                t1_load;
    logic                piv_load;
    logic                mag_load;
    logic                mul_sel_x;
    logic                div_start;
    logic                div_sel_acc;
    logic                f_load;
    logic                acc_load;
    logic                acc_sub;
    logic                x_rd;
    logic                x_wr;
    logic                out_load;
    logic                out_zero;
    logic                out_last;
    logic [STATUS_W-1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic better;
    logic singular;
    logic div_done;
    logic out_valid;
  } dp_stat_t;

endpackage

/* hdl/ges_divider.sv */
// Restoring fixed-point divider, one quotient bit per cycle, rounded and saturated.
module ges_divider import ges_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] num,
  input  logic signed [DATA_W-1:0] den,
  output logic                     done,
  output logic signed [DATA_W-1:0] quot
);

  localparam int DVW = DATA_W + FRACTION_BITS + 1;
  localparam int CW  = $clog2(DVW + 1);

  logic              active;
  logic [CW-1:0]     cnt;
  logic [DVW-1:0]    dvd;
  logic [DVW-1:0]    q;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dsr;
  logic              neg;
  logic              zero;

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   trial_sub;
  logic              qbit;

  assign mag_a = num[DATA_W-1] ? (~num + 1'b1) : num;
  assign mag_d = den[DATA_W-1] ? (~den + 1'b1) : den;
  assign trial = {rem, dvd[DVW-1]};
  assign trial_sub = trial - {1'b0, dsr};
  assign qbit = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CW'(DVW);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {1'b0, mag_a, {FRACTION_BITS{1'b0}}} + DVW'(mag_d >> 1);
      q    <= '0;
      rem  <= '0;
      dsr  <= mag_d;
      neg  <= num[DATA_W-1] ^ den[DATA_W-1];
      zero <= (mag_d == '0);
    end else if (active) begin
      dvd <= {dvd[DVW-2:0], 1'b0};
      q   <= {q[DVW-2:0], qbit};
      rem <= qbit ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
    end
  end

  always_comb begin
    if (zero) begin
      quot = '0;
    end else if (neg) begin
      if ((|q[DVW-1:DATA_W]) || (q[DATA_W-1] && (|q[DATA_W-2:0]))) begin
        quot = Q_MIN;
      end else begin
        quot = ~q[DATA_W-1:0] + 1'b1;
      end
    end else begin
      if (|q[DVW-1:DATA_W-1]) begin
        quot = Q_MAX;
      end else begin
        quot = q[DATA_W-1:0];
      end
    end
  end

endmodule

/* hdl/ges_datapath.sv */
// Datapath: matrix and solution memories, multiplier, divider and result register.
module ges_datapath import ges_pkg::*; #(
  parameter int MAX_ORDER     = DEF_MAX_ORDER,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int J_W           = $clog2(MAX_ORDER + 1),
  parameter int XA_W          = $clog2(MAX_ORDER),
  parameter int ADDR_W        = $clog2(MAX_ORDER * (MAX_ORDER + 1))
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic [J_W-1:0]           a_row,
  input  logic [J_W-1:0]           a_col,
  input  logic [ADDR_W-1:0]        lin,
  input  logic [XA_W-1:0]          x_idx,
  input  logic [J_W-1:0]           n_r,
  input  logic [J_W-1:0]           out_idx,
  input  logic signed [DATA_W-1:0] elem,
  input  logic [TOL_W-1:0]         tol,
  input  logic                     out_stall,
  output dp_stat_t                 stat,
  output logic                     out_valid,
  output out_item_t                out_data
);

  localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);
  localparam int AC_W  = 2 * J_W + 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] xmem [MAX_ORDER];

  logic signed [DATA_W-1:0] mem_q;
  logic signed [DATA_W-1:0] x_q;
  logic signed [DATA_W-1:0] t1;
  logic signed [DATA_W-1:0] piv;
  logic signed [DATA_W-1:0] f;
  logic signed [DATA_W-1:0] acc;
  logic signed [DATA_W-1:0] prod;
  logic signed [2*DATA_W-1:0] mul_p;
  logic [DATA_W-1:0]        best_mag;

  logic [AC_W-1:0]          addr_calc;
  logic [ADDR_W-1:0]        addr;
  logic signed [DATA_W-1:0] wdata;
  logic signed [DATA_W-1:0] mul_b;
  logic [DATA_W-1:0]        rd_mag;
  logic [2*DATA_W-1:0]      pm;
  logic [2*DATA_W-1:0]      pr;
  logic signed [DATA_W-1:0] prod_next;
  logic signed [DATA_W-1:0] diff;
  logic signed [DATA_W-1:0] acc_diff;
  logic signed [DATA_W-1:0] div_num;
  logic signed [DATA_W-1:0] div_den;
  logic signed [DATA_W-1:0] div_q;
  logic                     div_done;

  function automatic logic signed [DATA_W-1:0] sat_sub(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] d;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (d[DATA_W] != d[DATA_W-1]) begin
      return d[DATA_W] ? Q_MIN : Q_MAX;
    end
    return d[DATA_W-1:0];
  endfunction

  assign addr_calc = AC_W'(a_row) * AC_W'(n_r + 1'b1) + AC_W'(a_col);
  assign addr      = cmd.use_lin ? lin : ADDR_W'(addr_calc);
  assign rd_mag    = mem_q[DATA_W-1] ? (~mem_q + 1'b1) : mem_q;
  assign mul_b     = cmd.mul_sel_x ? x_q : f;
  assign diff      = sat_sub(mem_q, prod);
  assign acc_diff  = sat_sub(acc, prod);
  assign div_num   = cmd.div_sel_acc ? acc : mem_q;
  assign div_den   = cmd.div_sel_acc ? mem_q : piv;

  always_comb begin
    case (cmd.wr_src)
      WS_INPUT: wdata = elem;
      WS_MEMQ:  wdata = mem_q;
      WS_T1:    wdata = t1;
      WS_DIFF:  wdata = diff;
      default:  wdata = elem;
    endcase
  end

  always_comb begin
    pm = mul_p[2*DATA_W-1] ? (~mul_p + 1'b1) : mul_p;
    pr = (pm + ((2*DATA_W)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    if (mul_p[2*DATA_W-1]) begin
      prod_next = (pr > (2*DATA_W)'(64'h8000_0000)) ? Q_MIN : (~pr[DATA_W-1:0] + 1'b1);
    end else begin
      prod_next = (pr > (2*DATA_W)'(64'h7FFF_FFFF)) ? Q_MAX : pr[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.x_wr) begin
      xmem[x_idx] <= div_q;
    end
    if (cmd.x_rd) begin
      x_q <= xmem[x_idx];
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mem_q * mul_b;
    prod  <= prod_next;
    if (cmd.t1_load) begin
      t1 <= mem_q;
    end
    if (cmd.piv_load) begin
      piv <= mem_q;
    end
    if (cmd.mag_load) begin
      best_mag <= rd_mag;
    end
    if (cmd.f_load) begin
      f <= div_q;
    end
    if (cmd.acc_load) begin
      acc <= mem_q;
    end else if (cmd.acc_sub) begin
      acc <= acc_diff;
    end
  end

  ges_divider #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.solution_index <= cmd.out_zero ? '0 : OUT_IDX_W'(out_idx);
      out_data.solution_value <= cmd.out_zero ? '0 : x_q;
      out_data.solve_status   <= cmd.out_status;
      out_data.last_result    <= cmd.out_last;
    end
  end

  assign stat.better    = rd_mag > best_mag;
  assign stat.singular  = (best_mag < {1'b0, tol}) || (best_mag == '0);
  assign stat.div_done  = div_done;
  assign stat.out_valid = out_valid;

endmodule

/* hdl/ges_ctrl.sv */
// Controller: load counting and the elimination and substitution sequence.
module ges_ctrl import ges_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int J_W       = $clog2(MAX_ORDER + 1),
  parameter int XA_W      = $clog2(MAX_ORDER),
  parameter int ADDR_W    = $clog2(MAX_ORDER * (MAX_ORDER + 1))
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               last_element,
  output logic               in_stall,
  input  logic [ORDER_W-1:0] system_order,
  input  dp_stat_t           stat,
  output dp_cmd_t            cmd,
  output logic [J_W-1:0]     a_row,
  output logic [J_W-1:0]     a_col,
  output logic [ADDR_W-1:0]  lin,
  output logic [XA_W-1:0]    x_idx,
  output logic [J_W-1:0]     n_r,
  output logic [J_W-1:0]     out_idx
);

  localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);
  localparam int CNT_W = $clog2(DEPTH + 2);
  localparam int TW    = 2 * J_W + 1;

  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_P_RD   = 5'd1;
  localparam logic [4:0] S_P_CMP  = 5'd2;
  localparam logic [4:0] S_P_CHK  = 5'd3;
  localparam logic [4:0] S_SW_RD1 = 5'd4;
  localparam logic [4:0] S_SW_RD2 = 5'd5;
  localparam logic [4:0] S_SW_WR1 = 5'd6;
  localparam logic [4:0] S_SW_WR2 = 5'd7;
  localparam logic [4:0] S_V_RD   = 5'd8;
  localparam logic [4:0] S_V_LD   = 5'd9;
  localparam logic [4:0] S_F_RD   = 5'd10;
  localparam logic [4:0] S_F_DIV  = 5'd11;
  localparam logic [4:0] S_F_WAIT = 5'd12;
  localparam logic [4:0] S_E_RD1  = 5'd13;
  localparam logic [4:0] S_E_MUL  = 5'd14;
  localparam logic [4:0] S_E_RD2  = 5'd15;
  localparam logic [4:0] S_E_WR   = 5'd16;
  localparam logic [4:0] S_B_RD   = 5'd17;
  localparam logic [4:0] S_B_ACC  = 5'd18;
  localparam logic [4:0] S_M_RD   = 5'd19;
  localparam logic [4:0] S_M_W1   = 5'd20;
  localparam logic [4:0] S_M_W2   = 5'd21;
  localparam logic [4:0] S_M_SUB  = 5'd22;
  localparam logic [4:0] S_D_RD   = 5'd23;
  localparam logic [4:0] S_D_DIV  = 5'd24;
  localparam logic [4:0] S_D_WAIT = 5'd25;
  localparam logic [4:0] S_O_RD   = 5'd26;
  localparam logic [4:0] S_O_LD   = 5'd27;

  logic [4:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [J_W-1:0]   n_next;
  logic [J_W-1:0]   col, col_next;
  logic [J_W-1:0]   row, row_next;
  logic [J_W-1:0]   j, j_next;
  logic [J_W-1:0]   best, best_next;

  logic [J_W-1:0]   n_cur;
  logic [TW-1:0]    total_w;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] cnt_inc;
  logic [J_W-1:0]   nm1;
  logic             accept;

  always_comb begin
    if (system_order == '0) begin
      n_cur = J_W'(1);
    end else if (32'(system_order) > 32'(MAX_ORDER)) begin
      n_cur = J_W'(MAX_ORDER);
    end else begin
      n_cur = J_W'(system_order);
    end
  end

  assign total_w  = TW'(n_cur) * TW'(n_cur + 1'b1);
  assign total    = CNT_W'(total_w);
  assign cnt_inc  = (cnt < total) ? cnt + 1'b1 : total + 1'b1;
  assign nm1      = n_r - 1'b1;
  assign in_stall = (state != S_LOAD) || (stat.out_valid && last_element);
  assign accept   = in_valid && !in_stall;
  assign lin      = ADDR_W'(cnt);
  assign out_idx  = row;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    n_next     = n_r;
    col_next   = col;
    row_next   = row;
    j_next     = j;
    best_next  = best;
    cmd        = '0;
    a_row      = row;
    a_col      = col;
    x_idx      = row[XA_W-1:0];

    case (state)
      S_LOAD: begin
        if (accept) begin
          cmd.use_lin = 1'b1;
          cmd.wr_src  = WS_INPUT;
          cmd.mem_wr  = (cnt < total);
          cnt_next    = cnt_inc;
          if (last_element) begin
            cnt_next = '0;
            if (cnt_inc != total) begin
              cmd.out_load   = 1'b1;
              cmd.out_zero   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = ST_MISMATCH;
              row_next       = '0;
            end else begin
              n_next     = n_cur;
              col_next   = '0;
              row_next   = '0;
              best_next  = '0;
              state_next = S_P_RD;
            end
          end
        end
      end
      S_P_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_P_CMP;
      end
      S_P_CMP: begin
        if (row == col || stat.better) begin
          cmd.mag_load = 1'b1;
          best_next    = row;
        end
        if (row == nm1) begin
          state_next = S_P_CHK;
        end else begin
          row_next   = row + 1'b1;
          state_next = S_P_RD;
        end
      end
      S_P_CHK: begin
        if (stat.singular) begin
          cmd.out_load   = 1'b1;
          cmd.out_zero   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = ST_SINGULAR;
          a_row          = '0;
          row_next       = '0;
          state_next     = S_LOAD;
        end else if (best != col) begin
          j_next     = '0;
          state_next = S_SW_RD1;
        end else begin
          state_next = S_V_RD;
        end
      end
      S_SW_RD1: begin
        cmd.mem_rd = 1'b1;
        a_row      = col;
        a_col      = j;
        state_next = S_SW_RD2;
      end
      S_SW_RD2: begin
        cmd.mem_rd  = 1'b1;
        cmd.t1_load = 1'b1;
        a_row       = best;
        a_col       = j;
        state_next  = S_SW_WR1;
      end
      S_SW_WR1: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_src = WS_MEMQ;
        a_row      = col;
        a_col      = j;
        state_next = S_SW_WR2;
      end
      S_SW_WR2: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_src = WS_T1;
        a_row      = best;
        a_col      = j;
        if (j == n_r) begin
          state_next = S_V_RD;
        end else begin
          j_next     = j + 1'b1;
          state_next = S_SW_RD1;
        end
      end
      S_V_RD: begin
        cmd.mem_rd = 1'b1;
        a_row      = col;
        state_next = S_V_LD;
      end
      S_V_LD: begin
        cmd.piv_load = 1'b1;
        if (col == nm1) begin
          row_next   = nm1;
          state_next = S_B_RD;
        end else begin
          row_next   = col + 1'b1;
          state_next = S_F_RD;
        end
      end
      S_F_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_F_DIV;
      end
      S_F_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_F_WAIT;
      end
      S_F_WAIT: begin
        if (stat.div_done) begin
          cmd.f_load = 1'b1;
          j_next     = col + 1'b1;
          state_next = S_E_RD1;
        end
      end
      S_E_RD1: begin
        cmd.mem_rd = 1'b1;
        a_row      = col;
        a_col      = j;
        state_next = S_E_MUL;
      end
      S_E_MUL: begin
        state_next = S_E_RD2;
      end
      S_E_RD2: begin
        cmd.mem_rd = 1'b1;
        a_col      = j;
        state_next = S_E_WR;
      end
      S_E_WR: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_src = WS_DIFF;
        a_col      = j;
        if (j != n_r) begin
          j_next     = j + 1'b1;
          state_next = S_E_RD1;
        end else if (row == nm1) begin
          col_next   = col + 1'b1;
          row_next   = col + 1'b1;
          state_next = S_P_RD;
        end else begin
          row_next   = row + 1'b1;
          state_next = S_F_RD;
        end
      end
      S_B_RD: begin
        cmd.mem_rd = 1'b1;
        a_col      = n_r;
        state_next = S_B_ACC;
      end
      S_B_ACC: begin
        cmd.acc_load = 1'b1;
        if (row == nm1) begin
          state_next = S_D_RD;
        end else begin
          j_next     = row + 1'b1;
          state_next = S_M_RD;
        end
      end
      S_M_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.x_rd   = 1'b1;
        a_col      = j;
        x_idx      = j[XA_W-1:0];
        state_next = S_M_W1;
      end
      S_M_W1: begin
        cmd.mul_sel_x = 1'b1;
        state_next    = S_M_W2;
      end
      S_M_W2: begin
        state_next = S_M_SUB;
      end
      S_M_SUB: begin
        cmd.acc_sub = 1'b1;
        if (j == nm1) begin
          state_next = S_D_RD;
        end else begin
          j_next     = j + 1'b1;
          state_next = S_M_RD;
        end
      end
      S_D_RD: begin
        cmd.mem_rd = 1'b1;
        a_col      = row;
        state_next = S_D_DIV;
      end
      S_D_DIV: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_acc = 1'b1;
        state_next      = S_D_WAIT;
      end
      S_D_WAIT: begin
        cmd.div_sel_acc = 1'b1;
        if (stat.div_done) begin
          cmd.x_wr = 1'b1;
          if (row == '0) begin
            state_next = S_O_RD;
          end else begin
            row_next   = row - 1'b1;
            state_next = S_B_RD;
          end
        end
      end
      S_O_RD: begin
        cmd.x_rd   = 1'b1;
        state_next = S_O_LD;
      end
      S_O_LD: begin
        if (!stat.out_valid) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_last   = (row == nm1);
          if (row == nm1) begin
            state_next = S_LOAD;
          end else begin
            row_next   = row + 1'b1;
            state_next = S_O_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    n_r  <= n_next;
    col  <= col_next;
    row  <= row_next;
    j    <= j_next;
    best <= best_next;
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_valid)
    else $error("result loaded over a pending result");

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("matrix memory read and written in one cycle");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (col < n_r && row < n_r && best < n_r))
    else $error("row or column index beyond system order");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH + 1))
    else $error("load count beyond store depth");

  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !stat.div_done)
    else $error("divider finished immediately after start");

endmodule

/* hdl/gaussian_elimination_solver.sv */
// Top level of the Gaussian elimination solver with partial pivoting.
// Load takes the elements one by one into the matrix store; a solve then runs its
// multiply-subtracts, row swaps and divides, n*(n+1)/2 divides in all, on one shared
// multiplier and one bit-serial divider.
// Results leave n per solve, each held while out_stall is high; a status ends a failed one.
// Reset sets order 16 and tolerance 1 and clears the load count; the stores are not cleared.
module gaussian_elimination_solver import ges_pkg::*; #(
  parameter int MAX_ORDER     = DEF_MAX_ORDER,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOL_W-1:0]     cfg_data
);

  localparam int J_W    = $clog2(MAX_ORDER + 1);
  localparam int XA_W   = $clog2(MAX_ORDER);
  localparam int ADDR_W = $clog2(MAX_ORDER * (MAX_ORDER + 1));

  logic [ORDER_W-1:0] system_order;
  logic [TOL_W-1:0]   pivot_tolerance;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [J_W-1:0]    a_row;
  logic [J_W-1:0]    a_col;
  logic [ADDR_W-1:0] lin;
  logic [XA_W-1:0]   x_idx;
  logic [J_W-1:0]    n_r;
  logic [J_W-1:0]    out_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      system_order    <= ORDER_W'(16);
      pivot_tolerance <= TOL_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ORDER: system_order    <= cfg_data[ORDER_W-1:0];
        CFG_TOL:   pivot_tolerance <= cfg_data;
        default:   ;
      endcase
    end
  end

  ges_ctrl #(
    .MAX_ORDER(MAX_ORDER),
    .J_W      (J_W),
    .XA_W     (XA_W),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .last_element(in_data.last_element),
    .in_stall    (in_stall),
    .system_order(system_order),
    .stat        (stat),
    .cmd         (cmd),
    .a_row       (a_row),
    .a_col       (a_col),
    .lin         (lin),
    .x_idx       (x_idx),
    .n_r         (n_r),
    .out_idx     (out_idx)
  );

  ges_datapath #(
    .MAX_ORDER    (MAX_ORDER),
    .FRACTION_BITS(FRACTION_BITS),
    .J_W          (J_W),
    .XA_W         (XA_W),
    .ADDR_W       (ADDR_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .a_row    (a_row),
    .a_col    (a_col),
    .lin      (lin),
    .x_idx    (x_idx),
    .n_r      (n_r),
    .out_idx  (out_idx),
    .elem     (in_data.element_value),
    .tol      (pivot_tolerance),
    .out_stall(out_stall),
    .stat     (stat),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
